FILE: rtl/opn_pkg.sv
package opn_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 15;
  localparam int COORD_FRAC       = 8;
  localparam int T_FRAC           = 16;
  localparam int NORM_W           = 16;
  localparam int T_W              = 32;
  localparam int NUM_PTS          = 12;

  // edge differences, cross product terms and cross product
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int LEN_W   = $clog2(CROSS_W + 1);

  // block scaling keeps at most CM_W magnitude bits per component
  localparam int CM_W   = 31;
  localparam int SH_MAX = (CROSS_W > CM_W) ? CROSS_W - CM_W : 0;
  localparam int SH_W   = $clog2(SH_MAX + 2);

  localparam int NN_W   = 2 * CM_W + 2;
  localparam int RT_W   = NN_W / 2;
  localparam int TERM_W = CM_W + 1 + DIFF_W;
  localparam int DOT_W  = TERM_W + 2;

  // t = round(|d| * 2^24 / (nn * 2^s)) as (2N + D) / 2D
  localparam int TSH  = T_FRAC + COORD_FRAC + 1;
  localparam int TD_W = NN_W + SH_MAX + 1;
  localparam int TN_A = DOT_W + TSH;
  localparam int TN_W = ((TN_A > TD_W) ? TN_A : TD_W) + 1;
  localparam int TQ_W = T_W + 1;

  // normal divide: |c| <= r, so the quotient is at most 2^(F+1)
  localparam int NQ_W = NORMAL_FRAC_BITS + 2;
  localparam int NR_W = RT_W + NQ_W;

  localparam int FRONT_LAT = 9;
  localparam int SQ_LAT    = RT_W;
  localparam int ND_LAT    = NQ_W;
  localparam int TD_LAT    = TQ_W;
  localparam int T_DLY     = SQ_LAT + ND_LAT - TD_LAT;

  localparam longint NORM_POS_LIM = (64'd1 << (NORM_W - 1)) - 1;
  localparam longint NORM_NEG_LIM = 64'd1 << (NORM_W - 1);

  typedef struct packed {
    logic [2:0][CM_W-1:0] cm;
    logic [2:0]           cneg;
    logic                 degen;
    logic                 flip;
    logic                 tzero;
  } nside_t;

  typedef struct packed {
    logic            ovf;
    logic [TQ_W-1:0] q;
  } tres_t;

endpackage

FILE: rtl/oriented_plane_normal_core.sv
// Path from input word to output word: 9 front stages, 32 square-root stages,
// 17 normal-divide stages, 1 output register; the t divider runs beside the
// square root and is realigned by a 16-deep delay line.
// Throughput: one word per cycle; the whole pipeline holds while a result waits under
// out_stall.
// Reset (rst_n low, synchronous) empties the pipeline and sets orient_mode to 1.
module oriented_plane_normal_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p1_x,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p1_y,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p1_z,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p2_x,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p2_y,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p2_z,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p3_x,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p3_y,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p3_z,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p4_x,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p4_y,
  input  logic signed [opn_pkg::COORD_BITS-1:0] in_p4_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [opn_pkg::NORM_W-1:0]     out_normal_x,
  output logic signed [opn_pkg::NORM_W-1:0]     out_normal_y,
  output logic signed [opn_pkg::NORM_W-1:0]     out_normal_z,
  output logic signed [opn_pkg::T_W-1:0]        out_plane_param,
  output logic                                  out_degenerate
);

  localparam int NMW = opn_pkg::NORM_W;
  localparam int TW  = opn_pkg::T_W;
  localparam int QW  = opn_pkg::TQ_W;
  localparam int NQW = opn_pkg::NQ_W;
  localparam int DLY = opn_pkg::T_DLY;

  logic orient_r;
  logic adv;

  logic signed [opn_pkg::COORD_BITS-1:0] pin [opn_pkg::NUM_PTS];

  logic                      fr_valid;
  logic [opn_pkg::NN_W-1:0]  fr_nn;
  logic [opn_pkg::TN_W-1:0]  fr_tn;
  logic [opn_pkg::TD_W-1:0]  fr_td;
  opn_pkg::nside_t           fr_side;

  logic                      sq_valid;
  logic [opn_pkg::RT_W-1:0]  sq_root;
  opn_pkg::nside_t           sq_side;

  logic                      nd_valid;
  logic [NQW-1:0]            nd_q [3];
  opn_pkg::nside_t           nd_side;

  logic                      td_valid;
  opn_pkg::tres_t            td_res;

  opn_pkg::tres_t            tdl_r [DLY];
  logic [DLY-1:0]            tdl_v_r;

  logic                      out_valid_r;
  logic signed [NMW-1:0]     nrm_r [3];
  logic signed [TW-1:0]      t_r;
  logic                      degen_r;

  logic signed [NMW-1:0]     nrm_nxt [3];
  logic signed [TW-1:0]      t_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= 1'b1;
    end else if (cfg_wr_en) begin
      orient_r <= cfg_wr_data;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  assign pin[0]  = in_p1_x;
  assign pin[1]  = in_p1_y;
  assign pin[2]  = in_p1_z;
  assign pin[3]  = in_p2_x;
  assign pin[4]  = in_p2_y;
  assign pin[5]  = in_p2_z;
  assign pin[6]  = in_p3_x;
  assign pin[7]  = in_p3_y;
  assign pin[8]  = in_p3_z;
  assign pin[9]  = in_p4_x;
  assign pin[10] = in_p4_y;
  assign pin[11] = in_p4_z;

  opn_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .orient_mode (orient_r),
    .in_valid    (in_valid),
    .pin         (pin),
    .out_valid   (fr_valid),
    .nn          (fr_nn),
    .tn          (fr_tn),
    .td          (fr_td),
    .side        (fr_side)
  );

  opn_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .nn        (fr_nn),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  opn_tdiv u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (fr_valid),
    .tn        (fr_tn),
    .td        (fr_td),
    .out_valid (td_valid),
    .res       (td_res)
  );

  opn_ndiv u_ndiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .in_side   (sq_side),
    .out_valid (nd_valid),
    .q         (nd_q),
    .out_side  (nd_side)
  );

  // realign the t quotient with the normal path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tdl_v_r <= '0;
    end else if (adv) begin
      tdl_v_r <= {tdl_v_r[DLY-2:0], td_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tdl_r[0] <= td_res;
      for (int i = 1; i < DLY; i++) begin
        tdl_r[i] <= tdl_r[i-1];
      end
    end
  end

  // rounding, orientation sign, saturation and zeroing of degenerate faces
  always_comb begin
    logic [NQW-1:0]   vq;
    logic signed [NQW:0] nv;
    opn_pkg::tres_t   tr;
    tr = tdl_r[DLY-1];
    for (int k = 0; k < 3; k++) begin
      vq = NQW'(((NQW+1)'(nd_q[k]) + 1'b1) >> 1);
      nv = -$signed({1'b0, vq});
      if (nd_side.cneg[k] ^ nd_side.flip) begin
        nrm_nxt[k] = (64'(vq) > opn_pkg::NORM_NEG_LIM) ? NMW'(opn_pkg::NORM_NEG_LIM) : NMW'(nv);
      end else begin
        nrm_nxt[k] = (64'(vq) > opn_pkg::NORM_POS_LIM) ? NMW'(opn_pkg::NORM_POS_LIM) : NMW'(vq);
      end
    end
    if (nd_side.tzero) begin
      t_nxt = '0;
    end else if (nd_side.flip) begin
      t_nxt = (tr.ovf || tr.q > (QW'(1) << (TW - 1))) ? TW'(QW'(1) << (TW - 1))
                                                      : TW'(~tr.q + 1'b1);
    end else begin
      t_nxt = (tr.ovf || tr.q >= (QW'(1) << (TW - 1))) ? {1'b0, {(TW-1){1'b1}}} : TW'(tr.q);
    end
    if (nd_side.degen) begin
      for (int k = 0; k < 3; k++) begin
        nrm_nxt[k] = '0;
      end
      t_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= nd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nrm_r   <= nrm_nxt;
      t_r     <= t_nxt;
      degen_r <= nd_side.degen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_normal_x    = nrm_r[0];
  assign out_normal_y    = nrm_r[1];
  assign out_normal_z    = nrm_r[2];
  assign out_plane_param = t_r;
  assign out_degenerate  = degen_r;

`ifndef ASSERT_OFF
  a_t_align: assert property (@(posedge clk) disable iff (!rst_n)
    nd_valid == tdl_v_r[DLY-1])
    else $error("t quotient out of step with normal path");

  a_root_nz: assert property (@(posedge clk) disable iff (!rst_n)
    sq_valid && !sq_side.degen |-> sq_root != '0)
    else $error("zero length on a non-degenerate face");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_normal_x == '0 && out_normal_y == '0 &&
    out_normal_z == '0 && out_plane_param == '0)
    else $error("degenerate face with nonzero result");
`endif

endmodule

FILE: rtl/opn_front.sv
module opn_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   orient_mode,
  input  logic                                   in_valid,
  input  logic signed [opn_pkg::COORD_BITS-1:0]  pin [opn_pkg::NUM_PTS],
  output logic                                   out_valid,
  output logic [opn_pkg::NN_W-1:0]               nn,
  output logic [opn_pkg::TN_W-1:0]               tn,
  output logic [opn_pkg::TD_W-1:0]               td,
  output opn_pkg::nside_t                        side
);

  localparam int DW  = opn_pkg::DIFF_W;
  localparam int PW  = opn_pkg::PROD_W;
  localparam int XW  = opn_pkg::CROSS_W;
  localparam int CW  = opn_pkg::CM_W;
  localparam int SW  = opn_pkg::SH_W;
  localparam int TMW = opn_pkg::TERM_W;
  localparam int DTW = opn_pkg::DOT_W;
  localparam int LAT = opn_pkg::FRONT_LAT;

  logic [LAT-1:0] vld_r;

  logic signed [DW-1:0]  a_r [3];
  logic signed [DW-1:0]  b_r [3];
  logic signed [DW-1:0]  e1_r [3];
  logic signed [PW-1:0]  pm_r [6];
  logic signed [DW-1:0]  e2_r [3];
  logic signed [XW-1:0]  n_r [3];
  logic signed [DW-1:0]  e3_r [3];
  logic [XW-1:0]         mag4_r [3];
  logic [2:0]            neg4_r;
  logic [XW-1:0]         or4_r;
  logic signed [DW-1:0]  e4_r [3];
  logic [SW-1:0]         s5_r;
  logic [XW-1:0]         mag5_r [3];
  logic [2:0]            neg5_r;
  logic                  degen5_r;
  logic signed [DW-1:0]  e5_r [3];
  logic signed [CW:0]    c6_r [3];
  logic [CW-1:0]         cm6_r [3];
  logic [2:0]            neg6_r;
  logic                  degen6_r;
  logic [SW-1:0]         s6_r;
  logic signed [DW-1:0]  e6_r [3];
  logic [2*CW-1:0]       sq7_r [3];
  logic signed [TMW-1:0] tm7_r [3];
  logic [CW-1:0]         cm7_r [3];
  logic [2:0]            neg7_r;
  logic                  degen7_r;
  logic [SW-1:0]         s7_r;
  logic [opn_pkg::NN_W-1:0] nn8_r;
  logic signed [DTW-1:0] dot8_r;
  logic [CW-1:0]         cm8_r [3];
  logic [2:0]            neg8_r;
  logic                  degen8_r;
  logic [SW-1:0]         s8_r;
  logic [opn_pkg::NN_W-1:0] nn_r;
  logic [opn_pkg::TN_W-1:0] tn_r;
  logic [opn_pkg::TD_W-1:0] td_r;
  opn_pkg::nside_t       side_r;

  logic [opn_pkg::LEN_W-1:0] msb_len;
  logic [SW-1:0]             s_nxt;
  logic [CW-1:0]             cm_nxt [3];
  logic [DTW-1:0]            dmag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // bit length of the largest component = bit length of the OR of all three
  always_comb begin
    msb_len = '0;
    for (int i = 0; i < XW; i++) begin
      if (or4_r[i]) msb_len = opn_pkg::LEN_W'(i + 1);
    end
    s_nxt = (int'(msb_len) > CW) ? SW'(int'(msb_len) - CW) : '0;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cm_nxt[k] = CW'(mag5_r[k] >> s5_r);
    end
    dmag = dot8_r[DTW-1] ? DTW'(-dot8_r) : DTW'(dot8_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_r[k]  <= DW'(pin[k]) - DW'(pin[3+k]);
        b_r[k]  <= DW'(pin[k]) - DW'(pin[6+k]);
        e1_r[k] <= DW'(pin[9+k]) - DW'(pin[k]);
        e2_r[k] <= e1_r[k];
        e3_r[k] <= e2_r[k];
        e4_r[k] <= e3_r[k];
        e5_r[k] <= e4_r[k];
        e6_r[k] <= e5_r[k];
      end
      pm_r[0] <= PW'(a_r[1]) * PW'(b_r[2]);
      pm_r[1] <= PW'(a_r[2]) * PW'(b_r[1]);
      pm_r[2] <= PW'(a_r[2]) * PW'(b_r[0]);
      pm_r[3] <= PW'(a_r[0]) * PW'(b_r[2]);
      pm_r[4] <= PW'(a_r[0]) * PW'(b_r[1]);
      pm_r[5] <= PW'(a_r[1]) * PW'(b_r[0]);
      for (int k = 0; k < 3; k++) begin
        n_r[k]    <= XW'(pm_r[2*k]) - XW'(pm_r[2*k+1]);
        mag4_r[k] <= n_r[k][XW-1] ? XW'(-n_r[k]) : XW'(n_r[k]);
        neg4_r[k] <= n_r[k][XW-1];
      end
      or4_r <= (n_r[0][XW-1] ? XW'(-n_r[0]) : XW'(n_r[0]))
             | (n_r[1][XW-1] ? XW'(-n_r[1]) : XW'(n_r[1]))
             | (n_r[2][XW-1] ? XW'(-n_r[2]) : XW'(n_r[2]));

      s5_r     <= s_nxt;
      mag5_r   <= mag4_r;
      neg5_r   <= neg4_r;
      degen5_r <= (or4_r == '0);

      for (int k = 0; k < 3; k++) begin
        cm6_r[k] <= cm_nxt[k];
        c6_r[k]  <= neg5_r[k] ? -$signed({1'b0, cm_nxt[k]}) : $signed({1'b0, cm_nxt[k]});
      end
      neg6_r   <= neg5_r;
      degen6_r <= degen5_r;
      s6_r     <= s5_r;

      for (int k = 0; k < 3; k++) begin
        sq7_r[k] <= (2*CW)'(cm6_r[k]) * (2*CW)'(cm6_r[k]);
        tm7_r[k] <= TMW'(c6_r[k]) * TMW'(e6_r[k]);
      end
      cm7_r    <= cm6_r;
      neg7_r   <= neg6_r;
      degen7_r <= degen6_r;
      s7_r     <= s6_r;

      nn8_r <= opn_pkg::NN_W'(sq7_r[0]) + opn_pkg::NN_W'(sq7_r[1])
             + opn_pkg::NN_W'(sq7_r[2]);
      // plain mode: a zero dot gives t = 0 and no flip
      dot8_r <= orient_mode ? DTW'(tm7_r[0]) + DTW'(tm7_r[1]) + DTW'(tm7_r[2]) : '0;
      cm8_r    <= cm7_r;
      neg8_r   <= neg7_r;
      degen8_r <= degen7_r;
      s8_r     <= s7_r;

      nn_r <= nn8_r;
      tn_r <= (opn_pkg::TN_W'(dmag) << opn_pkg::TSH) + (opn_pkg::TN_W'(nn8_r) << s8_r);
      td_r <= (opn_pkg::TD_W'(nn8_r) << s8_r) << 1;
      for (int k = 0; k < 3; k++) begin
        side_r.cm[k] <= cm8_r[k];
      end
      side_r.cneg  <= neg8_r;
      side_r.degen <= degen8_r;
      side_r.tzero <= (dot8_r == '0);
      side_r.flip  <= !dot8_r[DTW-1] && (dot8_r != '0);
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign nn        = nn_r;
  assign tn        = tn_r;
  assign td        = td_r;
  assign side      = side_r;

endmodule

FILE: rtl/opn_sqrt.sv
module opn_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [opn_pkg::NN_W-1:0]    nn,
  input  opn_pkg::nside_t             in_side,
  output logic                        out_valid,
  output logic [opn_pkg::RT_W-1:0]    root,
  output opn_pkg::nside_t             out_side
);

  localparam int NW  = opn_pkg::NN_W;
  localparam int RW  = opn_pkg::RT_W;
  localparam int LAT = opn_pkg::SQ_LAT;

  logic [LAT-1:0]  vld_r;
  logic [NW-1:0]   rem_r  [LAT];
  logic [RW-1:0]   root_r [LAT];
  opn_pkg::nside_t side_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // one root bit per stage, rem holds x - root^2
  for (genvar g = 0; g < LAT; g++) begin : g_st
    localparam int B = LAT - 1 - g;
    logic [NW-1:0]   rem_in;
    logic [RW-1:0]   root_in;
    opn_pkg::nside_t side_in;
    logic [NW:0]     trial;
    logic            take;

    if (g == 0) begin : g_head
      assign rem_in  = nn;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign trial = ((NW+1)'(root_in) << (B + 1)) + ((NW+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= take ? NW'({1'b0, rem_in} - trial) : rem_in;
        root_r[g] <= take ? (root_in | (RW'(1) << B)) : root_in;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign root      = root_r[LAT-1];
  assign out_side  = side_r[LAT-1];

endmodule

FILE: rtl/opn_ndiv.sv
module opn_ndiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [opn_pkg::RT_W-1:0]    root,
  input  opn_pkg::nside_t             in_side,
  output logic                        out_valid,
  output logic [opn_pkg::NQ_W-1:0]    q [3],
  output opn_pkg::nside_t             out_side
);

  localparam int RW  = opn_pkg::RT_W;
  localparam int QW  = opn_pkg::NQ_W;
  localparam int MW  = opn_pkg::NR_W;
  localparam int LAT = opn_pkg::ND_LAT;

  logic [LAT-1:0]  vld_r;
  logic [MW-1:0]   rem_r  [LAT][3];
  logic [QW-1:0]   q_r    [LAT][3];
  logic [RW-1:0]   root_r [LAT];
  opn_pkg::nside_t side_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // three restoring dividers in lockstep, one quotient bit per stage
  for (genvar g = 0; g < LAT; g++) begin : g_st
    localparam int B = LAT - 1 - g;
    logic [MW-1:0]   rem_in [3];
    logic [QW-1:0]   q_in   [3];
    logic [RW-1:0]   root_in;
    opn_pkg::nside_t side_in;
    logic [MW-1:0]   dv;

    if (g == 0) begin : g_head
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = MW'(in_side.cm[k]) << (opn_pkg::NORMAL_FRAC_BITS + 1);
          q_in[k]   = '0;
        end
      end
      assign root_in = root;
      assign side_in = in_side;
    end else begin : g_body
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = rem_r[g-1][k];
          q_in[k]   = q_r[g-1][k];
        end
      end
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    assign dv = MW'(root_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (rem_in[k] >= dv) begin
            rem_r[g][k] <= rem_in[k] - dv;
            q_r[g][k]   <= q_in[k] | (QW'(1) << B);
          end else begin
            rem_r[g][k] <= rem_in[k];
            q_r[g][k]   <= q_in[k];
          end
        end
        root_r[g] <= root_in;
        side_r[g] <= side_in;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q[k] = q_r[LAT-1][k];
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_side  = side_r[LAT-1];

endmodule

FILE: rtl/opn_tdiv.sv
module opn_tdiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [opn_pkg::TN_W-1:0]    tn,
  input  logic [opn_pkg::TD_W-1:0]    td,
  output logic                        out_valid,
  output opn_pkg::tres_t              res
);

  localparam int NW  = opn_pkg::TN_W;
  localparam int DW  = opn_pkg::TD_W;
  localparam int QW  = opn_pkg::TQ_W;
  localparam int LAT = opn_pkg::TD_LAT;

  logic [LAT-1:0] vld_r;
  logic [NW-1:0]  rem_r [LAT];
  logic [DW-1:0]  td_r  [LAT];
  logic [QW-1:0]  q_r   [LAT];
  logic [LAT-1:0] ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < LAT; g++) begin : g_st
    localparam int B = LAT - 1 - g;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] td_in;
    logic [QW-1:0] q_in;
    logic          ovf_in;
    logic          take;

    if (g == 0) begin : g_head
      assign rem_in = tn;
      assign td_in  = td;
      assign q_in   = '0;
      // quotient too large for QW bits: saturates later
      assign ovf_in = (tn >> QW) >= NW'(td);
    end else begin : g_body
      assign rem_in = rem_r[g-1];
      assign td_in  = td_r[g-1];
      assign q_in   = q_r[g-1];
      assign ovf_in = ovf_r[g-1];
    end

    assign take = (rem_in >> B) >= NW'(td_in);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? rem_in - (NW'(td_in) << B) : rem_in;
        q_r[g]   <= take ? (q_in | (QW'(1) << B)) : q_in;
        td_r[g]  <= td_in;
        ovf_r[g] <= ovf_in;
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign res.ovf   = ovf_r[LAT-1];
  assign res.q     = q_r[LAT-1];

endmodule
